### hdl/cvs_pkg.sv
`timescale 1ns / 1ps

package cvs_pkg;

  // result queue between front and back end, power of two depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QLVL_W      = 2;

  typedef struct packed {
    logic              empty;
    logic [QLVL_W-1:0] level;
  } q_status_t;

  typedef enum logic [2:0] {
    BE_IDLE = 3'b001,
    BE_DIV  = 3'b010,
    BE_DONE = 3'b100
  } be_state_t;

endpackage

### hdl/cvs_front.sv
`timescale 1ns / 1ps

module cvs_front #(
  parameter int PART_WIDTH  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              push,
  output logic                                              full,
  input  logic signed [PART_WIDTH-1:0]                      sample_re,
  input  logic signed [PART_WIDTH-1:0]                      sample_im,
  input  logic                                              last_sample,
  input  cvs_pkg::q_status_t                                q_stat,
  output logic                                              q_push,
  output logic [2*(PART_WIDTH+COUNT_WIDTH)+4*PART_WIDTH+COUNT_WIDTH:0] q_data
);

  localparam int AW = PART_WIDTH + COUNT_WIDTH;
  localparam int MW = 2 * PART_WIDTH;

  logic                         accept;
  logic [cvs_pkg::QLVL_W:0]     need;

  logic                         s1_valid_r;
  logic                         s1_last_r;
  logic signed [PART_WIDTH-1:0] s1_re_r;
  logic signed [PART_WIDTH-1:0] s1_im_r;
  logic signed [MW-1:0]         s1_sq_re_r;
  logic signed [MW-1:0]         s1_sq_im_r;
  logic signed [MW-1:0]         sq_re;
  logic signed [MW-1:0]         sq_im;

  logic signed [AW-1:0]         acc_re_r, acc_re_nxt;
  logic signed [AW-1:0]         acc_im_r, acc_im_nxt;
  logic [PART_WIDTH-1:0]        top_re_r, top_re_nxt;
  logic [PART_WIDTH-1:0]        top_im_r, top_im_nxt;
  logic [MW-1:0]                top_mag_r, top_mag_nxt;
  logic [PART_WIDTH-1:0]        bot_re_r, bot_re_nxt;
  logic [PART_WIDTH-1:0]        bot_im_r, bot_im_nxt;
  logic [MW-1:0]                bot_mag_r, bot_mag_nxt;
  logic [COUNT_WIDTH-1:0]       cnt_r, cnt_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [MW-1:0]                mag;
  logic                         first;

  // a last item in stage one holds a reserved queue slot
  assign need   = {1'b0, q_stat.level} + {{cvs_pkg::QLVL_W{1'b0}}, s1_valid_r & s1_last_r};
  assign full   = need >= (cvs_pkg::QLVL_W + 1)'(cvs_pkg::QUEUE_DEPTH);
  assign accept = push & ~full;

  assign sq_re = sample_re * sample_re;
  assign sq_im = sample_im * sample_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r  <= last_sample;
      s1_re_r    <= sample_re;
      s1_im_r    <= sample_im;
      s1_sq_re_r <= sq_re;
      s1_sq_im_r <= sq_im;
    end
  end

  always_comb begin
    mag        = MW'(s1_sq_re_r) + MW'(s1_sq_im_r);
    first      = (cnt_r == '0);
    acc_re_nxt = acc_re_r + AW'(s1_re_r);
    acc_im_nxt = acc_im_r + AW'(s1_im_r);
    top_re_nxt  = top_re_r;
    top_im_nxt  = top_im_r;
    top_mag_nxt = top_mag_r;
    bot_re_nxt  = bot_re_r;
    bot_im_nxt  = bot_im_r;
    bot_mag_nxt = bot_mag_r;
    if (first || (mag > top_mag_r)) begin
      top_re_nxt  = s1_re_r;
      top_im_nxt  = s1_im_r;
      top_mag_nxt = mag;
    end
    if (first || (mag < bot_mag_r)) begin
      bot_re_nxt  = s1_re_r;
      bot_im_nxt  = s1_im_r;
      bot_mag_nxt = mag;
    end
    if (cnt_r == '1) begin
      cnt_nxt = cnt_r;
      ovf_nxt = 1'b1;
    end else begin
      cnt_nxt = cnt_r + COUNT_WIDTH'(1);
      ovf_nxt = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
    end else if (s1_valid_r) begin
      if (s1_last_r) begin
        acc_re_r <= '0;
        acc_im_r <= '0;
        cnt_r    <= '0;
        ovf_r    <= 1'b0;
      end else begin
        acc_re_r <= acc_re_nxt;
        acc_im_r <= acc_im_nxt;
        cnt_r    <= cnt_nxt;
        ovf_r    <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      top_re_r  <= top_re_nxt;
      top_im_r  <= top_im_nxt;
      top_mag_r <= top_mag_nxt;
      bot_re_r  <= bot_re_nxt;
      bot_im_r  <= bot_im_nxt;
      bot_mag_r <= bot_mag_nxt;
    end
  end

  assign q_push = s1_valid_r & s1_last_r;
  assign q_data = {acc_re_nxt, acc_im_nxt, top_re_nxt, top_im_nxt,
                   bot_re_nxt, bot_im_nxt, cnt_nxt, ovf_nxt};

endmodule

### hdl/cvs_queue.sv
`timescale 1ns / 1ps

module cvs_queue #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output cvs_pkg::q_status_t status
);

  logic [WIDTH-1:0]           mem_r [cvs_pkg::QUEUE_DEPTH];
  logic [cvs_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [cvs_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [cvs_pkg::QLVL_W-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + cvs_pkg::QLVL_W'(1);
    end else if (!push && pop) begin
      level_nxt = level_r - cvs_pkg::QLVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + cvs_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + cvs_pkg::QPTR_W'(1);
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata        = mem_r[rd_ptr_r];
  assign status.empty = (level_r == '0);
  assign status.level = level_r;

endmodule

### hdl/cvs_back.sv
`timescale 1ns / 1ps

module cvs_back #(
  parameter int PART_WIDTH  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cvs_pkg::q_status_t                     q_stat,
  input  logic [2*(PART_WIDTH+COUNT_WIDTH)+4*PART_WIDTH+COUNT_WIDTH:0] q_rdata,
  output logic                                   q_pop,
  input  logic                                   pop,
  output logic                                   empty,
  output logic signed [PART_WIDTH+COUNT_WIDTH-1:0] total_re,
  output logic signed [PART_WIDTH+COUNT_WIDTH-1:0] total_im,
  output logic signed [PART_WIDTH-1:0]           average_re,
  output logic signed [PART_WIDTH-1:0]           average_im,
  output logic signed [PART_WIDTH-1:0]           largest_re,
  output logic signed [PART_WIDTH-1:0]           largest_im,
  output logic signed [PART_WIDTH-1:0]           smallest_re,
  output logic signed [PART_WIDTH-1:0]           smallest_im,
  output logic [COUNT_WIDTH-1:0]                 sample_count,
  output logic                                   count_overflow
);

  localparam int AW     = PART_WIDTH + COUNT_WIDTH;
  localparam int ITER_W = $clog2(AW);
  localparam logic [AW-1:0] HI_MAG = {{(AW-PART_WIDTH+1){1'b0}}, {(PART_WIDTH-1){1'b1}}};
  localparam logic [AW-1:0] LO_MAG = HI_MAG + AW'(1);

  logic [AW-1:0]          q_acc_re, q_acc_im;
  logic [PART_WIDTH-1:0]  q_top_re, q_top_im, q_bot_re, q_bot_im;
  logic [COUNT_WIDTH-1:0] q_cnt;
  logic                   q_ovf;

  cvs_pkg::be_state_t     state_r, state_nxt;
  logic [ITER_W-1:0]      iter_r;
  logic [AW-1:0]          dvd_re_r, dvd_im_r;
  logic [COUNT_WIDTH-1:0] rem_re_r, rem_im_r;
  logic                   neg_re_r, neg_im_r;
  logic [AW-1:0]          tot_re_r, tot_im_r;
  logic [PART_WIDTH-1:0]  top_re_r, top_im_r, bot_re_r, bot_im_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic                   ovf_r;

  logic [COUNT_WIDTH:0]   sh_re, sh_im, sub_re, sub_im;
  logic                   ge_re, ge_im;
  logic [AW-1:0]          negm_re, negm_im;
  logic [PART_WIDTH-1:0]  avg_re, avg_im;
  logic                   out_valid_r;
  logic                   out_load;

  assign {q_acc_re, q_acc_im, q_top_re, q_top_im, q_bot_re, q_bot_im, q_cnt, q_ovf} = q_rdata;

  // one quotient bit per cycle for each part
  always_comb begin
    sh_re  = {rem_re_r, dvd_re_r[AW-1]};
    sh_im  = {rem_im_r, dvd_im_r[AW-1]};
    ge_re  = sh_re >= {1'b0, cnt_r};
    ge_im  = sh_im >= {1'b0, cnt_r};
    sub_re = ge_re ? (sh_re - {1'b0, cnt_r}) : sh_re;
    sub_im = ge_im ? (sh_im - {1'b0, cnt_r}) : sh_im;
  end

  // sign restore and saturation of the quotients
  always_comb begin
    negm_re = -dvd_re_r;
    negm_im = -dvd_im_r;
    if (neg_re_r) begin
      avg_re = (dvd_re_r > LO_MAG) ? {1'b1, {(PART_WIDTH-1){1'b0}}} : negm_re[PART_WIDTH-1:0];
    end else begin
      avg_re = (dvd_re_r > HI_MAG) ? {1'b0, {(PART_WIDTH-1){1'b1}}} : dvd_re_r[PART_WIDTH-1:0];
    end
    if (neg_im_r) begin
      avg_im = (dvd_im_r > LO_MAG) ? {1'b1, {(PART_WIDTH-1){1'b0}}} : negm_im[PART_WIDTH-1:0];
    end else begin
      avg_im = (dvd_im_r > HI_MAG) ? {1'b0, {(PART_WIDTH-1){1'b1}}} : dvd_im_r[PART_WIDTH-1:0];
    end
  end

  assign q_pop    = (state_r == cvs_pkg::BE_IDLE) & ~q_stat.empty;
  assign out_load = (state_r == cvs_pkg::BE_DONE) & (~out_valid_r | pop);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cvs_pkg::BE_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = cvs_pkg::BE_DIV;
        end
      end
      cvs_pkg::BE_DIV: begin
        if (iter_r == '0) begin
          state_nxt = cvs_pkg::BE_DONE;
        end
      end
      cvs_pkg::BE_DONE: begin
        if (out_load) begin
          state_nxt = cvs_pkg::BE_IDLE;
        end
      end
      default: begin
        state_nxt = cvs_pkg::BE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cvs_pkg::BE_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg_re_r <= q_acc_re[AW-1];
      neg_im_r <= q_acc_im[AW-1];
      dvd_re_r <= q_acc_re[AW-1] ? -q_acc_re : q_acc_re;
      dvd_im_r <= q_acc_im[AW-1] ? -q_acc_im : q_acc_im;
      rem_re_r <= '0;
      rem_im_r <= '0;
      iter_r   <= ITER_W'(AW - 1);
      tot_re_r <= q_acc_re;
      tot_im_r <= q_acc_im;
      top_re_r <= q_top_re;
      top_im_r <= q_top_im;
      bot_re_r <= q_bot_re;
      bot_im_r <= q_bot_im;
      cnt_r    <= q_cnt;
      ovf_r    <= q_ovf;
    end else if (state_r == cvs_pkg::BE_DIV) begin
      dvd_re_r <= {dvd_re_r[AW-2:0], ge_re};
      dvd_im_r <= {dvd_im_r[AW-2:0], ge_im};
      rem_re_r <= sub_re[COUNT_WIDTH-1:0];
      rem_im_r <= sub_im[COUNT_WIDTH-1:0];
      iter_r   <= iter_r - ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      total_re       <= tot_re_r;
      total_im       <= tot_im_r;
      average_re     <= avg_re;
      average_im     <= avg_im;
      largest_re     <= top_re_r;
      largest_im     <= top_im_r;
      smallest_re    <= bot_re_r;
      smallest_im    <= bot_im_r;
      sample_count   <= cnt_r;
      count_overflow <= ovf_r;
    end
  end

  assign empty = ~out_valid_r;

endmodule

### hdl/complex_vector_statistics_unit.sv
`timescale 1ns / 1ps
// path: the last sample goes through stage one, the result queue and the back-end divider to the output registers
// throughput: one sample per cycle while full is low; each vector result occupies the back-end divider
//   (one quotient bit per cycle), buffered by a 2-entry queue
// reset: rst_n synchronous active low, clears sums, count, queue and result valid

module complex_vector_statistics_unit #(
  parameter int PART_WIDTH  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     push,
  output logic                                     full,
  input  logic signed [PART_WIDTH-1:0]             in_sample_re,
  input  logic signed [PART_WIDTH-1:0]             in_sample_im,
  input  logic                                     in_last_sample,
  output logic                                     empty,
  input  logic                                     pop,
  output logic signed [PART_WIDTH+COUNT_WIDTH-1:0] out_total_re,
  output logic signed [PART_WIDTH+COUNT_WIDTH-1:0] out_total_im,
  output logic signed [PART_WIDTH-1:0]             out_average_re,
  output logic signed [PART_WIDTH-1:0]             out_average_im,
  output logic signed [PART_WIDTH-1:0]             out_largest_re,
  output logic signed [PART_WIDTH-1:0]             out_largest_im,
  output logic signed [PART_WIDTH-1:0]             out_smallest_re,
  output logic signed [PART_WIDTH-1:0]             out_smallest_im,
  output logic [COUNT_WIDTH-1:0]                   out_sample_count,
  output logic                                     out_count_overflow
);

  localparam int RW = 2 * (PART_WIDTH + COUNT_WIDTH) + 4 * PART_WIDTH + COUNT_WIDTH + 1;

  cvs_pkg::q_status_t q_stat;
  logic               q_push;
  logic               q_pop;
  logic [RW-1:0]      q_wdata;
  logic [RW-1:0]      q_rdata;

  cvs_front #(
    .PART_WIDTH  (PART_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .sample_re   (in_sample_re),
    .sample_im   (in_sample_im),
    .last_sample (in_last_sample),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  cvs_queue #(
    .WIDTH (RW)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_stat)
  );

  cvs_back #(
    .PART_WIDTH  (PART_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .total_re       (out_total_re),
    .total_im       (out_total_im),
    .average_re     (out_average_re),
    .average_im     (out_average_im),
    .largest_re     (out_largest_re),
    .largest_im     (out_largest_im),
    .smallest_re    (out_smallest_re),
    .smallest_im    (out_smallest_im),
    .sample_count   (out_sample_count),
    .count_overflow (out_count_overflow)
  );

endmodule

### dv/complex_vector_statistics_unit_tb.sv
`timescale 1ns / 1ps

module complex_vector_statistics_unit_tb;

  localparam int PW = 16;
  localparam int CW = 16;
  localparam int AW = PW + CW;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int DRAIN_CYCLES = 2 * (AW + 4);
  localparam int NUM_ROWS = 23;
  localparam int HOLD_CYCLES = 600;
  localparam int TX_IDLE [4] = '{0, 53, 0, 14};
  localparam int RX_STALL [4] = '{0, 0, 53, 14};

  typedef struct packed {
    logic signed [AW-1:0] total_re;
    logic signed [AW-1:0] total_im;
    logic signed [PW-1:0] average_re;
    logic signed [PW-1:0] average_im;
    logic signed [PW-1:0] largest_re;
    logic signed [PW-1:0] largest_im;
    logic signed [PW-1:0] smallest_re;
    logic signed [PW-1:0] smallest_im;
    logic [CW-1:0]        sample_count;
    logic                 count_overflow;
  } vec_result_t;

  typedef struct {
    int re;
    int im;
    bit is_last;
    bit known;
    int want [10];
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 pop = 1'b0;
  logic signed [PW-1:0] in_sample_re = '0;
  logic signed [PW-1:0] in_sample_im = '0;
  logic                 in_last_sample = 1'b0;
  logic                 full;
  logic                 empty;
  logic signed [AW-1:0] out_total_re;
  logic signed [AW-1:0] out_total_im;
  logic signed [PW-1:0] out_average_re;
  logic signed [PW-1:0] out_average_im;
  logic signed [PW-1:0] out_largest_re;
  logic signed [PW-1:0] out_largest_im;
  logic signed [PW-1:0] out_smallest_re;
  logic signed [PW-1:0] out_smallest_im;
  logic [CW-1:0]        out_sample_count;
  logic                 out_count_overflow;

  // running statistics of the vector being collected
  logic signed [AW-1:0] vs_sum_re;
  logic signed [AW-1:0] vs_sum_im;
  logic signed [PW-1:0] vs_top_re;
  logic signed [PW-1:0] vs_top_im;
  logic [2*PW-1:0]      vs_top_mag;
  logic signed [PW-1:0] vs_bot_re;
  logic signed [PW-1:0] vs_bot_im;
  logic [2*PW-1:0]      vs_bot_mag;
  logic [CW-1:0]        vs_seen;
  logic                 vs_sat;

  vec_result_t stats_due [$];
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycle_count = 0;

  stim_row_t stim_table [NUM_ROWS] = '{
    '{0, 0, 1, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0}},
    '{32767, -32768, 1, 1,
      '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 1, 0}},
    '{-32768, 32767, 1, 1,
      '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 1, 0}},
    '{-1, -1, 1, 1, '{-1, -1, -1, -1, -1, -1, -1, -1, 1, 0}},
    // equal magnitudes, the earlier sample wins
    '{3, 4, 0, 0, '{default: 0}},
    '{5, 0, 0, 0, '{default: 0}},
    '{-4, -3, 0, 0, '{default: 0}},
    '{0, -5, 1, 0, '{default: 0}},
    '{1, 1, 0, 0, '{default: 0}},
    '{100, -100, 0, 0, '{default: 0}},
    '{-32768, -32768, 0, 0, '{default: 0}},
    '{0, 0, 0, 0, '{default: 0}},
    '{32767, 32767, 0, 0, '{default: 0}},
    '{2, 2, 1, 0, '{default: 0}},
    // mean truncates toward zero
    '{-7, 7, 0, 0, '{default: 0}},
    '{0, 0, 0, 0, '{default: 0}},
    '{0, 1, 1, 0, '{default: 0}},
    '{0, 0, 0, 0, '{default: 0}},
    '{0, 0, 0, 0, '{default: 0}},
    '{-32768, 0, 0, 0, '{default: 0}},
    '{0, -32768, 1, 0, '{default: 0}},
    '{255, -256, 0, 0, '{default: 0}},
    '{-256, 255, 1, 0, '{default: 0}}
  };

  always #6 clk = ~clk;

  complex_vector_statistics_unit #(
    .PART_WIDTH (PW),
    .COUNT_WIDTH(CW)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_sample_re      (in_sample_re),
    .in_sample_im      (in_sample_im),
    .in_last_sample    (in_last_sample),
    .empty             (empty),
    .pop               (pop),
    .out_total_re      (out_total_re),
    .out_total_im      (out_total_im),
    .out_average_re    (out_average_re),
    .out_average_im    (out_average_im),
    .out_largest_re    (out_largest_re),
    .out_largest_im    (out_largest_im),
    .out_smallest_re   (out_smallest_re),
    .out_smallest_im   (out_smallest_im),
    .out_sample_count  (out_sample_count),
    .out_count_overflow(out_count_overflow)
  );

  function automatic logic [2*PW-1:0] power_of(logic signed [PW-1:0] re,
                                               logic signed [PW-1:0] im);
    longint a;
    longint b;
    a = re;
    b = im;
    return (2*PW)'(a * a + b * b);
  endfunction

  function automatic logic signed [PW-1:0] mean_part(logic signed [AW-1:0] s,
                                                     logic [CW-1:0] n);
    longint q;
    longint hi;
    hi = (longint'(1) <<< (PW - 1)) - 1;
    q = longint'(s) / longint'(n);
    if (q > hi) q = hi;
    if (q < -hi - 1) q = -hi - 1;
    return PW'(q);
  endfunction

  function automatic vec_result_t to_result(int w [10]);
    vec_result_t r;
    r.total_re = w[0];
    r.total_im = w[1];
    r.average_re = PW'(w[2]);
    r.average_im = PW'(w[3]);
    r.largest_re = PW'(w[4]);
    r.largest_im = PW'(w[5]);
    r.smallest_re = PW'(w[6]);
    r.smallest_im = PW'(w[7]);
    r.sample_count = CW'(w[8]);
    r.count_overflow = w[9][0];
    return r;
  endfunction

  function automatic logic signed [PW-1:0] rand_part();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return $urandom_range(1) ? 16'sh0001 : 16'shffff;
      4, 5: return PW'(int'($urandom_range(15)) - 8);
      default: return PW'($urandom);
    endcase
  endfunction

  task automatic clear_stats();
    vs_sum_re = '0;
    vs_sum_im = '0;
    vs_top_re = '0;
    vs_top_im = '0;
    vs_top_mag = '0;
    vs_bot_re = '0;
    vs_bot_im = '0;
    vs_bot_mag = '0;
    vs_seen = '0;
    vs_sat = 1'b0;
  endtask

  task automatic fold_sample(input logic signed [PW-1:0] re, input logic signed [PW-1:0] im,
                             input logic is_last, output bit done, output vec_result_t res);
    logic [2*PW-1:0] mag;
    mag = power_of(re, im);
    vs_sum_re = vs_sum_re + AW'(re);
    vs_sum_im = vs_sum_im + AW'(im);
    if (vs_seen == '0) begin
      vs_top_re = re;
      vs_top_im = im;
      vs_top_mag = mag;
      vs_bot_re = re;
      vs_bot_im = im;
      vs_bot_mag = mag;
    end else begin
      if (mag > vs_top_mag) begin
        vs_top_re = re;
        vs_top_im = im;
        vs_top_mag = mag;
      end
      if (mag < vs_bot_mag) begin
        vs_bot_re = re;
        vs_bot_im = im;
        vs_bot_mag = mag;
      end
    end
    if (vs_seen == {CW{1'b1}}) vs_sat = 1'b1;
    else vs_seen = vs_seen + 1'b1;
    done = is_last;
    res = '0;
    if (is_last) begin
      res.total_re = vs_sum_re;
      res.total_im = vs_sum_im;
      res.average_re = mean_part(vs_sum_re, vs_seen);
      res.average_im = mean_part(vs_sum_im, vs_seen);
      res.largest_re = vs_top_re;
      res.largest_im = vs_top_im;
      res.smallest_re = vs_bot_re;
      res.smallest_im = vs_bot_im;
      res.sample_count = vs_seen;
      res.count_overflow = vs_sat;
      clear_stats();
    end
  endtask

  task automatic send_sample(input int re, input int im, input bit is_last, input bit known,
                             input vec_result_t want);
    bit done;
    vec_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    in_sample_re <= PW'(re);
    in_sample_im <= PW'(im);
    in_last_sample <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    fold_sample(PW'(re), PW'(im), is_last, done, res);
    if (done) stats_due.push_back(known ? want : res);
    items_sent++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      pop <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    vec_result_t got;
    vec_result_t want;
    if (rst_n && pop && !empty) begin
      got = {out_total_re, out_total_im, out_average_re, out_average_im,
             out_largest_re, out_largest_im, out_smallest_re, out_smallest_im,
             out_sample_count, out_count_overflow};
      if (stats_due.size() == 0) begin
        report_mismatch("transfer with no result pending");
      end else begin
        want = stats_due.pop_front();
        check_field("total_re", got.total_re, want.total_re);
        check_field("total_im", got.total_im, want.total_im);
        check_field("average_re", got.average_re, want.average_re);
        check_field("average_im", got.average_im, want.average_im);
        check_field("largest_re", got.largest_re, want.largest_re);
        check_field("largest_im", got.largest_im, want.largest_im);
        check_field("smallest_re", got.smallest_re, want.smallest_re);
        check_field("smallest_im", got.smallest_im, want.smallest_im);
        check_field("sample_count", got.sample_count, want.sample_count);
        check_field("count_overflow", got.count_overflow, want.count_overflow);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[complex_vector_statistics_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int target;
    int len;
    clear_stats();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_sample(stim_table[i].re, stim_table[i].im, stim_table[i].is_last,
                  stim_table[i].known, to_result(stim_table[i].want));
    end

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct = TX_IDLE[ph];
      rx_stall_pct = RX_STALL[ph];
      if (ph == 0) begin
        rx_hold = HOLD_CYCLES;
        for (int k = 0; k < 40; k++) send_sample(rand_part(), rand_part(), 1, 0, '0);
        @(negedge clk);
        push <= 1'b0;
        while (stats_due.size() != 0) @(posedge clk);
      end
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) begin
        if ($urandom_range(99) < 70) len = $urandom_range(6, 1);
        else if ($urandom_range(99) < 85) len = $urandom_range(30, 7);
        else len = $urandom_range(200, 31);
        for (int j = 0; j < len; j++) send_sample(rand_part(), rand_part(), j == len - 1, 0, '0);
      end
    end

    @(negedge clk);
    push <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("[complex_vector_statistics_unit] OK");
    else $display("[complex_vector_statistics_unit] ERROR");
    $finish;
  end

endmodule

### sim.f
hdl/cvs_pkg.sv
hdl/cvs_front.sv
hdl/cvs_queue.sv
hdl/cvs_back.sv
hdl/complex_vector_statistics_unit.sv
dv/complex_vector_statistics_unit_tb.sv
